/* rtl/spq_pkg.sv */
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ITEM_W = 32;
  localparam int PRIO_W = 32;
  localparam int COUNT_W = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic signed [ITEM_W-1:0] item;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } ctl_t;

endpackage

/* rtl/spq_cell.sv */
module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = spq_pkg::COUNT_W
) (
  input  logic               clk,
  input  spq_pkg::ctl_t      ctl_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               left_gt_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               gt_o,
  output spq_pkg::entry_t    ent_o
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic            occ;

  assign occ  = count_i > CNT_W'(IDX);
  assign gt_o = occ && (ent_r.prio > ctl_i.ent.prio);
  assign ent_o = ent_r;

  // insert: keep if strictly greater, else take new entry at the boundary,
  // else shift right from the left neighbor; dequeue: take the right neighbor
  always_comb begin
    ent_nxt = ent_r;
    if (ctl_i.enq) begin
      if (!gt_o) begin
        if (left_gt_i) begin
          ent_nxt = ctl_i.ent;
        end else begin
          ent_nxt = left_i;
        end
      end
    end else if (ctl_i.deq) begin
      ent_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

/* rtl/sorted_priority_queue_top.sv */
// A result beat appears on the output register in the cycle after its input beat.
// One command per cycle if not stalled; all cells of the row compare and shift in parallel.
// A new beat is taken while the held result is being taken, or when none is held.
// Reset (rst_n low, synchronous): queue empty, count zero, no result held, input not ready.
// Slot contents are not cleared; only occupied slots ever reach the output.
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] in_item, [63:32] in_priority
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] out_item, [63:32] out_priority, [65:64] status,
                                  // [66] queue_empty, [71:67] entry_count
  output logic        out_tuser   // [0] out_valid
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  acc;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  full;
  logic                  empty;
  spq_pkg::ctl_t         ctl;
  spq_pkg::entry_t       ents [CAPACITY];
  logic                  gts  [CAPACITY];

  logic                  ovld_r;
  logic                  dvld_r;
  logic                  dvld_nxt;
  spq_pkg::entry_t       dent_r;
  spq_pkg::entry_t       dent_nxt;
  logic [1:0]            st_r;
  logic [1:0]            st_nxt;
  logic [CNT_W+4:0]      count_ext;

  assign in_tready = rst_n && (!ovld_r || out_tready);
  assign acc       = in_tvalid && in_tready;
  assign full      = count_r == CNT_W'(CAPACITY);
  assign empty     = count_r == '0;

  assign ctl.enq      = acc && (in_tuser == spq_pkg::CMD_ENQ) && !full;
  assign ctl.deq      = acc && (in_tuser == spq_pkg::CMD_DEQ) && !empty;
  assign ctl.ent.item = in_tdata[31:0];
  assign ctl.ent.prio = in_tdata[63:32];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      spq_pkg::entry_t left_ent;
      spq_pkg::entry_t right_ent;
      logic            left_gt;
      if (g == 0) begin : g_first
        assign left_ent = ctl.ent;
        assign left_gt  = 1'b1;
      end else begin : g_mid
        assign left_ent = ents[g-1];
        assign left_gt  = gts[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_ent = ents[g];
      end else begin : g_inner
        assign right_ent = ents[g+1];
      end
      spq_cell #(
        .IDX   (g),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .ctl_i     (ctl),
        .count_i   (count_r),
        .left_gt_i (left_gt),
        .left_i    (left_ent),
        .right_i   (right_ent),
        .gt_o      (gts[g]),
        .ent_o     (ents[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    dvld_nxt  = 1'b0;
    dent_nxt  = '0;
    st_nxt    = spq_pkg::ST_OK;
    if (ctl.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.deq) begin
      count_nxt = count_r - CNT_W'(1);
      dvld_nxt  = 1'b1;
      dent_nxt  = ents[0];
    end else if (in_tuser == spq_pkg::CMD_ENQ) begin
      st_nxt = spq_pkg::ST_FULL;
    end else begin
      st_nxt = spq_pkg::ST_UNDERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (acc) begin
        count_r <= count_nxt;
        ovld_r  <= 1'b1;
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dvld_r <= dvld_nxt;
      dent_r <= dent_nxt;
      st_r   <= st_nxt;
    end
  end

  assign count_ext  = (CNT_W + 5)'(count_r);
  assign out_tvalid = ovld_r;
  assign out_tuser  = dvld_r;
  assign out_tdata  = {count_ext[4:0], (count_r == '0), st_r, dent_r.prio, dent_r.item};

endmodule

/* verif/sorted_priority_queue_top_test.sv */
module sorted_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = spq_pkg::CAPACITY_DEF;
  localparam int DIRECTED_FILL = 9;
  localparam int RANDOM_CMDS = 1630;
  localparam int PHASE_LEN = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic            cmd;
    spq_pkg::entry_t ent;
  } pq_cmd_t;

  typedef struct packed {
    logic                              got_entry;
    logic signed [spq_pkg::ITEM_W-1:0] item;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [1:0]                        status;
    logic                              empty;
    logic [spq_pkg::COUNT_W-1:0]       count;
  } pq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = spq_pkg::CMD_ENQ;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;

  pq_cmd_t    pending_cmds[$];
  pq_result_t expected_results[$];
  pq_result_t want;
  pq_cmd_t    next_cmd;

  spq_pkg::entry_t pq_slot[DEPTH];
  int              pq_len = 0;

  logic in_beat_taken = 1'b0;
  logic out_beat_taken = 1'b0;
  logic rx_hold = 1'b0;
  logic send_busy;
  int   send_wait = 0;
  int   send_run = 0;
  bit   send_calm = 1'b0;
  int   recv_wait = 0;
  int   recv_run = 0;
  bit   recv_calm = 1'b0;
  int   accepted_cmds = 0;
  int   results_seen = 0;
  int   total_cmds = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   hold_marks[2] = '{300, 1100};

  sorted_priority_queue_top #(
    .CAPACITY(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // insert behind strictly greater priorities, ahead of equal ones
  function automatic pq_result_t pq_apply(pq_cmd_t c);
    pq_result_t r;
    int pos;
    r = '0;
    if (c.cmd == spq_pkg::CMD_ENQ) begin
      if (pq_len >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < pq_len && $signed(pq_slot[pos].prio) > $signed(c.ent.prio)) pos++;
        for (int k = pq_len; k > pos; k--) pq_slot[k] = pq_slot[k-1];
        pq_slot[pos] = c.ent;
        pq_len++;
        r.status = spq_pkg::ST_OK;
      end
    end else if (pq_len == 0) begin
      r.status = spq_pkg::ST_UNDERFLOW;
    end else begin
      r.got_entry = 1'b1;
      r.item = pq_slot[0].item;
      r.prio = pq_slot[0].prio;
      for (int k = 1; k < pq_len; k++) pq_slot[k-1] = pq_slot[k];
      pq_len--;
      r.status = spq_pkg::ST_OK;
    end
    r.empty = (pq_len == 0);
    r.count = pq_len[spq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic int draw_gap(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    if (calm) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [31:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_cmd(logic cmd, logic [31:0] item, logic [31:0] prio);
    pq_cmd_t c;
    c.cmd = cmd;
    c.ent.item = item;
    c.ent.prio = prio;
    pending_cmds.push_back(c);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch on %s at result %0d: got %h, want %h", field, results_seen, got,
             exp_val);
    error_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(field, got, exp_val);
  endtask

  // monitor: check result beats, then predict accepted command beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_beat_taken <= 1'b0;
      out_beat_taken <= 1'b0;
    end else begin
      out_beat_taken <= out_tvalid && out_tready;
      in_beat_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          check_field("out_valid", out_tuser, want.got_entry);
          check_field("out_item", out_tdata[31:0], want.item);
          check_field("out_priority", out_tdata[63:32], want.prio);
          check_field("status", out_tdata[65:64], want.status);
          check_field("queue_empty", out_tdata[66], want.empty);
          check_field("entry_count", out_tdata[71:67], want.count);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(pq_apply({in_tuser, in_tdata[31:0], in_tdata[63:32]}));
        accepted_cmds++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      send_busy = in_tvalid && !in_beat_taken;
      if (in_tvalid && in_beat_taken) send_wait = draw_gap(send_run, send_calm);
      if (!send_busy) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_cmd.cmd;
          in_tdata <= {next_cmd.ent.prio, next_cmd.ent.item};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_beat_taken) recv_wait = draw_gap(recv_run, recv_calm);
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the queue backs up into the input
  initial begin
    foreach (hold_marks[i]) begin
      while (accepted_cmds < hold_marks[i]) @(negedge clk);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    int enq_pct;
    logic cmd;

    push_cmd(spq_pkg::CMD_DEQ, $urandom(), $urandom());
    push_cmd(spq_pkg::CMD_ENQ, 32'h0000_0000, 32'h0000_0000);
    push_cmd(spq_pkg::CMD_ENQ, 32'h0000_0001, 32'h0000_0000);
    push_cmd(spq_pkg::CMD_ENQ, 32'h8000_0000, 32'h7fff_ffff);
    push_cmd(spq_pkg::CMD_ENQ, 32'h7fff_ffff, 32'h8000_0000);
    push_cmd(spq_pkg::CMD_ENQ, 32'hffff_ffff, 32'h7fff_ffff);
    push_cmd(spq_pkg::CMD_ENQ, 32'h0000_0002, 32'hffff_ffff);
    push_cmd(spq_pkg::CMD_ENQ, 32'h0000_0003, 32'h0000_0001);
    for (int i = 0; i < DIRECTED_FILL; i++)
      push_cmd(spq_pkg::CMD_ENQ, $urandom(), $urandom_range(0, 4) - 2);
    push_cmd(spq_pkg::CMD_ENQ, 32'h1234_5678, 32'h0000_0005);
    push_cmd(spq_pkg::CMD_ENQ, 32'h8765_4321, 32'h7fff_ffff);
    repeat (3) push_cmd(spq_pkg::CMD_DEQ, $urandom(), $urandom());

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      case ((i / PHASE_LEN) % 4)
        0: enq_pct = 80;
        1: enq_pct = 20;
        2: enq_pct = 50;
        default: enq_pct = 60;
      endcase
      cmd = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
      push_cmd(cmd, $urandom(), (cmd == spq_pkg::CMD_ENQ) ? pick_prio() : $urandom());
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (results_seen < total_cmds) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("sorted_priority_queue_top_test: done, clean");
    end else begin
      $display("sorted_priority_queue_top_test: done, errors");
    end
    $finish;
  end

endmodule
